// ----- design/assert_macros.svh -----
// Assertion helpers for the design folder.
// Define ASSERT_OFF to compile all checks away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Check that an expression holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error("assertion failed");

// Check that a consequent holds in the same cycle as its antecedent.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

`else

`define ASSERT_ALWAYS(label, clk, rst_n, expr)
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)

`endif

`endif

// ----- design/lpd_pkg.sv -----
`default_nettype none

package lpd_pkg;

	localparam int COUNT_BITS = 25;
	localparam int LIMIT_BITS = 25;
	localparam int ACC_BITS   = 32;
	localparam int WHOLE_BITS = ACC_BITS + 2;

	typedef logic [COUNT_BITS-1:0] count_t;
	typedef logic [LIMIT_BITS-1:0] limit_t;
	typedef logic [ACC_BITS-1:0]   accum_t;
	typedef logic signed [WHOLE_BITS-1:0] whole_t;

	// Largest length that the position counter can hold
	localparam whole_t CNT_MAX = whole_t'((64'd1 << COUNT_BITS) - 64'd1);

	// Frame modes
	localparam logic [1:0] MODE_LEN16 = 2'd0;
	localparam logic [1:0] MODE_LEN32 = 2'd1;
	localparam logic [1:0] MODE_HDR24 = 2'd2;
	localparam logic [1:0] MODE_HEX6  = 2'd3;

	// Result status codes
	localparam logic [1:0] STAT_OK   = 2'd0;
	localparam logic [1:0] STAT_BAD  = 2'd1;
	localparam logic [1:0] STAT_DROP = 2'd2;

	// Configuration register indexes
	localparam int CFG_IDX_BITS = 2;
	localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_MODE    = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_MAX_FRAME_LEN = 2'd1;

	// Header geometry
	localparam logic [4:0] HDR_LEN16 = 5'd2;
	localparam logic [4:0] HDR_LEN32 = 5'd4;
	localparam logic [4:0] HDR_HDR24 = 5'd24;
	localparam logic [4:0] HDR_HEX6  = 5'd6;
	localparam logic [3:0] RDY_LEN16 = 4'd1;
	localparam logic [3:0] RDY_LEN32 = 4'd3;
	localparam logic [3:0] RDY_HDR24 = 4'd11;
	localparam logic [3:0] RDY_HEX6  = 4'd5;
	localparam logic [3:0] LEN_FIELD_LO = 4'd8;

	// ASCII hex digit: bit 4 marks a valid digit, bits 3:0 its value
	function automatic logic [4:0] hex_digit(input logic [7:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b1, 4'(c - 8'h30)};
		end else if (c >= 8'h61 && c <= 8'h66) begin
			r = {1'b1, 4'(c - 8'h57)};
		end else if (c >= 8'h41 && c <= 8'h46) begin
			r = {1'b1, 4'(c - 8'h37)};
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ----- design/length_prefix_deframer.sv -----
// Length-prefix deframer: splits a byte stream into messages.
// Input words arrive on s_tvalid/s_tready/s_tdata, one byte per word.
// Every byte leaves on m_tvalid/m_tready/m_tdata unchanged; m_tlast marks
// the byte that closes a message, m_tuser carries the first-byte flag and
// a status code (message byte, bad length found here, dropped).
// The cfg channel writes frame_mode (index 0) and max_frame_len (index 1);
// cfg_ready is always high. A frame_mode write restarts framing.
// Each accepted input word is registered in the output register.
// Throughput: one word per cycle while the receiver keeps up; all framing work for a byte is a single
// combinational pass (header shift-accumulate, length check, position
// compare) ahead of the output register.
// When the receiver stalls, the output register holds its word and
// s_tready drops until that word is taken.
// Reset clears the framing state and the error latch, loads frame_mode 0
// and max_frame_len 65536, and empties the output register.
// A bad length latches a drop state that only reset clears.
`default_nettype none

`include "assert_macros.svh"

module length_prefix_deframer (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  s_tvalid,
	output logic                                       s_tready,
	input  wire logic [7:0]                            s_tdata,   // [7:0] in_byte
	output logic                                       m_tvalid,
	input  wire logic                                  m_tready,
	output logic [7:0]                                 m_tdata,   // [7:0] out_byte
	output logic                                       m_tlast,   // frame_last
	output logic [2:0]                                 m_tuser,   // [0] frame_first, [2:1] status
	input  wire logic                                  cfg_valid,
	output logic                                       cfg_ready,
	input  wire logic [lpd_pkg::CFG_IDX_BITS-1:0]      cfg_index,
	input  wire logic [lpd_pkg::LIMIT_BITS-1:0]        cfg_data
);
	import lpd_pkg::*;

	logic [1:0] frame_mode_q;
	limit_t     max_len_q;
	count_t     byte_index_q, byte_index_nx;
	count_t     frame_total_q, frame_total_nx;
	accum_t     accum_q, accum_nx;
	logic       hex_stopped_q, hex_stopped_nx;
	logic       error_q, error_nx;

	logic       first_w, last_w;
	logic [1:0] status_w;
	logic [4:0] hdr_w;
	logic [3:0] ready_w;
	logic [4:0] digit_w;
	whole_t     whole_w;
	logic       bad_w;
	count_t     index_inc_w;

	logic       in_acc, cfg_wr;

	assign in_acc    = s_tvalid && s_tready;
	assign cfg_wr    = cfg_valid && cfg_ready;
	assign cfg_ready = 1'b1;
	assign s_tready  = !m_tvalid || m_tready;

	// Header geometry per mode
	always_comb begin
		case (frame_mode_q)
			MODE_LEN16: begin hdr_w = HDR_LEN16; ready_w = RDY_LEN16; end
			MODE_LEN32: begin hdr_w = HDR_LEN32; ready_w = RDY_LEN32; end
			MODE_HDR24: begin hdr_w = HDR_HDR24; ready_w = RDY_HDR24; end
			default:    begin hdr_w = HDR_HEX6;  ready_w = RDY_HEX6;  end
		endcase
	end

	assign digit_w     = hex_digit(s_tdata);
	assign index_inc_w = byte_index_q + count_t'(1);

	// Frame one byte: gather length, check it, advance the position
	always_comb begin
		byte_index_nx  = byte_index_q;
		frame_total_nx = frame_total_q;
		accum_nx       = accum_q;
		hex_stopped_nx = hex_stopped_q;
		error_nx       = error_q;
		first_w        = (byte_index_q == '0);
		last_w         = 1'b0;
		status_w       = STAT_OK;
		whole_w        = '0;
		bad_w          = 1'b0;

		if (error_q) begin
			first_w  = 1'b0;
			status_w = STAT_DROP;
		end else begin
			if (frame_total_q == '0) begin
				// Shift header bytes into the length
				case (frame_mode_q)
					MODE_LEN16, MODE_LEN32: begin
						accum_nx = {accum_q[ACC_BITS-9:0], s_tdata};
					end
					MODE_HDR24: begin
						if (byte_index_q >= count_t'(LEN_FIELD_LO) &&
						    byte_index_q <= count_t'(RDY_HDR24)) begin
							accum_nx = {accum_q[ACC_BITS-9:0], s_tdata};
						end
					end
					default: begin
						if (!hex_stopped_q) begin
							if (!digit_w[4]) begin
								hex_stopped_nx = 1'b1;
							end else begin
								accum_nx = {8'd0, accum_q[19:0], digit_w[3:0]};
							end
						end
					end
				endcase

				// Check the whole length on the last length byte
				if (byte_index_q == count_t'(ready_w)) begin
					case (frame_mode_q)
						MODE_LEN16: whole_w = whole_t'({1'b0, accum_nx[15:0]});
						MODE_LEN32: whole_w = whole_t'($signed(accum_nx));
						MODE_HDR24: whole_w = whole_t'($signed(accum_nx)) + whole_t'(24);
						default:    whole_w = whole_t'({1'b0, accum_nx[23:0]}) + whole_t'(6);
					endcase
					bad_w = (whole_w < whole_t'({1'b0, hdr_w})) ||
					        (whole_w > whole_t'({1'b0, max_len_q})) ||
					        (whole_w > CNT_MAX);
					if (bad_w) begin
						status_w = STAT_BAD;
						error_nx = 1'b1;
					end else begin
						frame_total_nx = whole_w[COUNT_BITS-1:0];
					end
				end
			end

			// Close the message or advance the position
			if (!bad_w) begin
				if (frame_total_nx != '0 && index_inc_w == frame_total_nx) begin
					last_w         = 1'b1;
					byte_index_nx  = '0;
					frame_total_nx = '0;
					accum_nx       = '0;
					hex_stopped_nx = 1'b0;
				end else begin
					byte_index_nx = index_inc_w;
				end
			end
		end
	end

	// Hold configuration and framing state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_mode_q  <= MODE_LEN16;
			max_len_q     <= limit_t'(65536);
			byte_index_q  <= '0;
			frame_total_q <= '0;
			accum_q       <= '0;
			hex_stopped_q <= 1'b0;
			error_q       <= 1'b0;
		end else if (cfg_wr) begin
			if (cfg_index == REG_FRAME_MODE) begin
				frame_mode_q  <= cfg_data[1:0];
				byte_index_q  <= '0;
				frame_total_q <= '0;
				accum_q       <= '0;
				hex_stopped_q <= 1'b0;
			end else if (cfg_index == REG_MAX_FRAME_LEN) begin
				max_len_q <= cfg_data;
			end
		end else if (in_acc) begin
			byte_index_q  <= byte_index_nx;
			frame_total_q <= frame_total_nx;
			accum_q       <= accum_nx;
			hex_stopped_q <= hex_stopped_nx;
			error_q       <= error_nx;
		end
	end

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (in_acc) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (in_acc) begin
			m_tdata <= s_tdata;
			m_tlast <= last_w;
			m_tuser <= {status_w, first_w};
		end
	end

	`ASSERT_IMPLIES(a_drop_needs_latch, clk, arst_n, m_tvalid && m_tuser[2:1] == STAT_DROP, error_q)
	`ASSERT_IMPLIES(a_err_not_last, clk, arst_n, m_tvalid && m_tuser[2:1] != STAT_OK, !m_tlast)
	`ASSERT_IMPLIES(a_pos_in_frame, clk, arst_n, frame_total_q != '0, byte_index_q < frame_total_q)
	`ASSERT_IMPLIES(a_pos_in_header, clk, arst_n, frame_total_q == '0, byte_index_q <= count_t'(RDY_HDR24))

endmodule

`default_nettype wire

// ----- verif/tb_length_prefix_deframer.sv -----
`default_nettype none

module tb_length_prefix_deframer;
	import lpd_pkg::*;

	localparam int WATCHDOG_CYCLES = 4000;
	localparam int RANDOM_ITEMS    = 800;

	// Indexes past the register list; writes there must be ignored
	localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_A = 2'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_B = 2'd3;

	typedef struct packed {
		logic [7:0] data;
		logic       first;
		logic       last;
		logic [1:0] status;
	} deframed_word_t;

	// Predicts the tagged byte stream and checks the output words against it
	class deframe_scoreboard;
		logic [1:0]     mode;
		limit_t         max_len;
		count_t         pos;
		longint         msg_len;
		accum_t         len_acc;
		bit             hex_done;
		bit             dropping;
		deframed_word_t pending_words[$];
		int             errors;
		int             n_closed;
		int             n_bad;
		int             n_dropped;

		function new();
			mode = MODE_LEN16;
			max_len = limit_t'(65536);
			dropping = 0;
			errors = 0;
			n_closed = 0;
			n_bad = 0;
			n_dropped = 0;
			restart_msg();
		endfunction

		function void restart_msg();
			pos = '0;
			msg_len = 0;
			len_acc = '0;
			hex_done = 0;
		endfunction

		function void apply_cfg(logic [CFG_IDX_BITS-1:0] idx, limit_t val);
			if (idx == REG_FRAME_MODE) begin
				mode = val[1:0];
				restart_msg();
			end else if (idx == REG_MAX_FRAME_LEN) begin
				max_len = val;
			end
		endfunction

		function int pending();
			return pending_words.size();
		endfunction

		// Work out the tags of one accepted input byte
		function void note_byte(logic [7:0] b);
			deframed_word_t w;
			int hdr, rdy, digit;
			longint whole, lim;
			w.data = b;
			w.first = 1'b0;
			w.last = 1'b0;
			w.status = STAT_OK;
			if (dropping) begin
				w.status = STAT_DROP;
				n_dropped++;
				pending_words.push_back(w);
				return;
			end
			w.first = (pos == 0);
			case (mode)
			MODE_LEN16: begin
				hdr = 2;
				rdy = 1;
			end
			MODE_LEN32: begin
				hdr = 4;
				rdy = 3;
			end
			MODE_HDR24: begin
				hdr = 24;
				rdy = 11;
			end
			default: begin
				hdr = 6;
				rdy = 5;
			end
			endcase
			if (msg_len == 0) begin
				// gather length bits from the header
				if (mode == MODE_LEN16 || mode == MODE_LEN32) begin
					len_acc = {len_acc[23:0], b};
				end else if (mode == MODE_HDR24) begin
					if (pos >= 8 && pos <= 11) begin
						len_acc = {len_acc[23:0], b};
					end
				end else if (!hex_done) begin
					digit = -1;
					if (b >= 8'h30 && b <= 8'h39) begin
						digit = b - 8'h30;
					end else if (b >= 8'h61 && b <= 8'h66) begin
						digit = b - 8'h57;
					end else if (b >= 8'h41 && b <= 8'h46) begin
						digit = b - 8'h37;
					end
					if (digit < 0) begin
						hex_done = 1;
					end else begin
						len_acc = {8'h00, len_acc[19:0], 4'(digit)};
					end
				end
				// check the length on the byte that completes it
				if (pos == rdy) begin
					case (mode)
					MODE_LEN16: whole = longint'(len_acc[15:0]);
					MODE_LEN32: whole = longint'($signed(len_acc));
					MODE_HDR24: whole = longint'($signed(len_acc)) + 24;
					default:    whole = longint'(len_acc) + 6;
					endcase
					lim = (longint'(1) << COUNT_BITS) - 1;
					if (longint'(max_len) < lim) begin
						lim = longint'(max_len);
					end
					if (whole < longint'(hdr) || whole > lim) begin
						w.status = STAT_BAD;
						dropping = 1;
						n_bad++;
						pending_words.push_back(w);
						return;
					end
					msg_len = whole;
				end
			end
			if (msg_len != 0 && longint'(pos) + 1 == msg_len) begin
				w.last = 1'b1;
				n_closed++;
				restart_msg();
			end else begin
				pos = pos + 1'b1;
			end
			pending_words.push_back(w);
		endfunction

		// Compare one output word with the oldest prediction
		function void check_word(logic [7:0] d, logic l, logic [2:0] u);
			deframed_word_t e, got;
			got.data = d;
			got.first = u[0];
			got.last = l;
			got.status = u[2:1];
			if (pending_words.size() == 0) begin
				errors++;
				$display("%0t: output word with nothing predicted: ", $time,
					"byte=%02h first=%0b last=%0b status=%0d",
					got.data, got.first, got.last, got.status);
				return;
			end
			e = pending_words.pop_front();
			if (got !== e) begin
				errors++;
				if (errors <= 40) begin
					$display("%0t: mismatch: ", $time,
						"expected byte=%02h first=%0b last=%0b status=%0d, ",
						e.data, e.first, e.last, e.status,
						"got byte=%02h first=%0b last=%0b status=%0d",
						got.data, got.first, got.last, got.status);
				end
			end
		endfunction
	endclass

	logic                    clk;
	logic                    arst_n;
	logic                    s_tvalid;
	logic                    s_tready;
	logic [7:0]              s_tdata;
	logic                    m_tvalid;
	logic                    m_tready;
	logic [7:0]              m_tdata;
	logic                    m_tlast;
	logic [2:0]              m_tuser;
	logic                    cfg_valid;
	logic                    cfg_ready;
	logic [CFG_IDX_BITS-1:0] cfg_index;
	limit_t                  cfg_data;

	deframe_scoreboard sb;
	int                idle_cycles = 0;
	int                burst_left = 0;
	int                sent_items = 0;
	int                n_phases = 0;
	logic [1:0]        cur_mode = MODE_LEN16;
	longint            cur_limit = 65536;

	length_prefix_deframer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Watch both streams and the config channel; stop on a long silence
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				sb.check_word(m_tdata, m_tlast, m_tuser);
			end
			if (s_tvalid && s_tready) begin
				sb.note_byte(s_tdata);
			end
			if ((m_tvalid && m_tready) || (s_tvalid && s_tready) || (cfg_valid && cfg_ready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
			if (idle_cycles >= WATCHDOG_CYCLES) begin
				$display("tb: failure");
				$finish;
			end
		end
	end

	// Stall the receiver in stretches of changing pattern
	initial begin
		int pat, span, k;
		m_tready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			pat = $urandom_range(0, 3);
			span = $urandom_range(8, 120);
			for (k = 0; k < span; k++) begin
				@(posedge clk);
				case (pat)
				0:       m_tready <= 1'b1;
				1:       m_tready <= ($urandom_range(0, 3) != 0);
				2:       m_tready <= ($urandom_range(0, 2) == 0);
				default: m_tready <= ((k % 9) < 5);
				endcase
			end
		end
	end

	function automatic int header_len(logic [1:0] m);
		case (m)
		MODE_LEN16: return int'(HDR_LEN16);
		MODE_LEN32: return int'(HDR_LEN32);
		MODE_HDR24: return int'(HDR_HDR24);
		default:    return int'(HDR_HEX6);
		endcase
	endfunction

	// Send one word, with a random gap at the start of each burst
	task automatic send_byte(input logic [7:0] b);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 30);
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata <= b;
		do @(posedge clk); while (!s_tready);
		sent_items++;
	endtask

	// Hold the sender until every predicted word has come out
	task automatic drain();
		s_tvalid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input limit_t val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		sb.apply_cfg(idx, val);
		if (idx == REG_FRAME_MODE) begin
			cur_mode = val[1:0];
		end else if (idx == REG_MAX_FRAME_LEN) begin
			cur_limit = longint'(val);
		end
		@(posedge clk);
	endtask

	// Send a header that announces a whole length in the current mode
	task automatic send_header(input longint whole);
		logic [31:0] field;
		logic [7:0]  c;
		int          value, ndig, nib, tmp, i;
		case (cur_mode)
		MODE_LEN16: begin
			field = 32'(whole);
			send_byte(field[15:8]);
			send_byte(field[7:0]);
		end
		MODE_LEN32: begin
			field = 32'(whole);
			for (i = 3; i >= 0; i--) send_byte(field[8*i +: 8]);
		end
		MODE_HDR24: begin
			field = 32'(whole - 24);
			for (i = 0; i < 24; i++) begin
				if (i >= 8 && i <= 11) begin
					send_byte(field[8*(11-i) +: 8]);
				end else begin
					send_byte(8'($urandom_range(0, 255)));
				end
			end
		end
		default: begin
			// digits with random leading zeros and case, then, if under six digits, a stop char and filler
			value = int'(whole - 6);
			tmp = value;
			ndig = 0;
			while (tmp != 0) begin
				ndig++;
				tmp = tmp >> 4;
			end
			ndig = $urandom_range(ndig, 6);
			for (i = 0; i < 6; i++) begin
				if (i < ndig) begin
					nib = (value >> (4 * (ndig - 1 - i))) & 15;
					if (nib < 10) begin
						c = 8'(48 + nib);
					end else begin
						c = 8'((($urandom_range(0, 1) != 0) ? 55 : 87) + nib);
					end
				end else if (i == ndig) begin
					case ($urandom_range(0, 3))
					0:       c = 8'($urandom_range(0, 47));
					1:       c = 8'($urandom_range(58, 64));
					2:       c = 8'($urandom_range(71, 96));
					default: c = 8'($urandom_range(103, 255));
					endcase
				end else begin
					c = 8'($urandom_range(0, 255));
				end
				send_byte(c);
			end
		end
		endcase
	endtask

	// Send a whole message; a cut one stops somewhere in its body
	task automatic send_message(input longint whole, input bit cut);
		longint nbody, k;
		send_header(whole);
		nbody = whole - longint'(header_len(cur_mode));
		if (cut) begin
			nbody = longint'($urandom_range(0, int'(nbody)));
		end
		for (k = 0; k < nbody; k++) send_byte(8'($urandom_range(0, 255)));
	endtask

	function automatic longint pick_whole();
		longint w;
		longint hdr;
		int     r;
		hdr = longint'(header_len(cur_mode));
		r = $urandom_range(0, 11);
		if (r == 0) begin
			w = hdr;
		end else if (r == 1) begin
			w = hdr + longint'($urandom_range(40, 250));
		end else if (r == 2 && cur_limit <= 300) begin
			w = cur_limit;
		end else begin
			w = hdr + longint'($urandom_range(1, 24));
		end
		if (w > cur_limit) begin
			w = cur_limit;
		end
		return w;
	endfunction

	initial begin
		int     start_random, nmsg, k, sel, kind;
		limit_t val;
		longint whole;
		sb = new();
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= 8'h00;
		cfg_valid <= 1'b0;
		cfg_index <= REG_FRAME_MODE;
		cfg_data <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: reset defaults, spare indexes, header-only and short messages
		write_reg(REG_SPARE_A, limit_t'($urandom));
		write_reg(REG_SPARE_B, '1);
		send_header(2);
		send_header(3);
		send_byte(8'hff);
		drain();
		write_reg(REG_FRAME_MODE, limit_t'(MODE_LEN32));
		send_header(4);
		send_header(5);
		send_byte(8'h00);
		drain();
		write_reg(REG_FRAME_MODE, limit_t'(MODE_HEX6));
		send_header(6);
		send_header(7);
		send_byte(8'h80);
		start_random = sent_items;

		// Random phases: new mode each time, sometimes a new limit
		while (sent_items < start_random + RANDOM_ITEMS) begin
			drain();
			if (n_phases < 4) begin
				val = limit_t'(n_phases);
			end else begin
				val = {23'($urandom), 2'($urandom_range(0, 3))};
			end
			write_reg(REG_FRAME_MODE, val);
			if ((n_phases >= 1 && n_phases <= 4) || $urandom_range(0, 2) == 0) begin
				sel = (n_phases >= 1 && n_phases <= 4) ? n_phases - 1 : $urandom_range(0, 4);
				case (sel)
				0:       val = limit_t'((64'd1 << LIMIT_BITS) - 1);
				1:       val = limit_t'(24'hffffff) + 1'b1;
				2:       val = limit_t'($urandom_range(60, 200));
				3:       val = limit_t'(65536);
				default: val = limit_t'($urandom_range(201, (1 << LIMIT_BITS) - 1));
				endcase
				write_reg(REG_MAX_FRAME_LEN, val);
			end
			nmsg = $urandom_range(2, 8);
			for (k = 0; k < nmsg; k++) begin
				send_message(pick_whole(), k == nmsg - 1 && $urandom_range(0, 3) == 0);
			end
			n_phases++;
		end

		// Finish with one bad length, then words that must be dropped
		drain();
		kind = $urandom_range(0, 3);
		case (kind)
		0: begin
			write_reg(REG_FRAME_MODE, limit_t'($urandom_range(0, 2)));
			whole = longint'($urandom_range(0, header_len(cur_mode) - 1));
		end
		1: begin
			write_reg(REG_FRAME_MODE,
				limit_t'(($urandom_range(0, 1) != 0) ? MODE_LEN32 : MODE_HDR24));
			whole = -longint'($urandom_range(1, 32'h7fffffff));
		end
		2: begin
			write_reg(REG_FRAME_MODE, limit_t'($urandom_range(0, 3)));
			write_reg(REG_MAX_FRAME_LEN, limit_t'($urandom_range(24, 60)));
			whole = cur_limit + longint'($urandom_range(1, 20));
		end
		default: begin
			write_reg(REG_FRAME_MODE, limit_t'($urandom_range(0, 3)));
			write_reg(REG_MAX_FRAME_LEN, limit_t'($urandom_range(0, 1)));
			whole = longint'(header_len(cur_mode)) + longint'($urandom_range(0, 10));
		end
		endcase
		send_header(whole);
		for (k = 0; k < 16; k++) send_byte(8'($urandom_range(0, 255)));

		drain();
		repeat (4) @(posedge clk);
		$display("tb: %0d words sent (%0d random) over %0d config phases in all four modes",
			sent_items, sent_items - start_random, n_phases);
		$display("tb: %0d messages closed, %0d bad length, %0d words dropped, %0d errors",
			sb.n_closed, sb.n_bad, sb.n_dropped, sb.errors);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

`default_nettype wire
